### sv/spn16_block_cipher_defines.svh
// ----------------------------------------------------------------------------
// spn16_block_cipher_defines.svh
// Assertion macros shared by the cipher RTL.
// ----------------------------------------------------------------------------
`ifndef SPN16_BLOCK_CIPHER_DEFINES_SVH
`define SPN16_BLOCK_CIPHER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is asserted.
`define SPN16_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define SPN16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPN16_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPN16_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/spn16_pkg.sv
// ----------------------------------------------------------------------------
// spn16_pkg
// Types, tables and helper functions of the 16-bit SPN cipher.
// ----------------------------------------------------------------------------
package spn16_pkg;

  localparam int unsigned ROUNDS_DEF = 5;
  localparam int unsigned BLK_W      = 16;

  typedef logic [BLK_W-1:0] blk_t;

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_KEYGEN,
    ST_IDLE,
    ST_RUN
  } state_e;

  // Control of one pass through the shared round unit.
  typedef struct packed {
    logic dec;
    logic perm;
    logic sub;
  } rnd_ctrl_t;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'd6, 4'd4, 4'd12, 4'd5, 4'd0, 4'd7, 4'd2, 4'd14,
    4'd1, 4'd15, 4'd3, 4'd13, 4'd8, 4'd10, 4'd9, 4'd11
  };

  localparam logic [3:0] SBOX_INV [16] = '{
    4'd4, 4'd8, 4'd6, 4'd10, 4'd1, 4'd3, 4'd0, 4'd5,
    4'd12, 4'd14, 4'd13, 4'd15, 4'd2, 4'd11, 4'd7, 4'd9
  };

  // Output bit i takes input bit BIT_SRC[i]; a 4x4 transpose.
  localparam logic [3:0] BIT_SRC [16] = '{
    4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
  };

  function automatic blk_t sub_nibbles(input blk_t x, input logic inv);
    blk_t r;
    r = '0;
    for (int n = 0; n < 4; n++) begin
      if (inv) begin
        r[4*n +: 4] = SBOX_INV[x[4*n +: 4]];
      end else begin
        r[4*n +: 4] = SBOX_FWD[x[4*n +: 4]];
      end
    end
    return r;
  endfunction

  function automatic blk_t transpose16(input blk_t x);
    blk_t r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[i] = x[BIT_SRC[i]];
    end
    return r;
  endfunction

endpackage

### sv/spn16_req_if.sv
// ----------------------------------------------------------------------------
// spn16_req_if
// Request channel: operation and input block with valid/ready.
// ----------------------------------------------------------------------------
interface spn16_req_if import spn16_pkg::*;;
  logic valid;
  logic ready;
  logic req_type;
  blk_t block_in;

  modport source (output valid, output req_type, output block_in, input ready);
  modport sink   (input valid, input req_type, input block_in, output ready);
endinterface

### sv/spn16_rsp_if.sv
// ----------------------------------------------------------------------------
// spn16_rsp_if
// Response channel: output block with valid/ready.
// ----------------------------------------------------------------------------
interface spn16_rsp_if import spn16_pkg::*;;
  logic valid;
  logic ready;
  blk_t block_out;

  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

### sv/spn16_round.sv
// ----------------------------------------------------------------------------
// spn16_round
// Shared round unit: key xor, then S-box and transpose in cipher order,
// or transpose and inverse S-box in decipher order.
// ----------------------------------------------------------------------------
module spn16_round import spn16_pkg::*; (
  input  blk_t      state_i,
  input  blk_t      key_i,
  input  rnd_ctrl_t ctrl_i,
  output blk_t      result_o
);

  blk_t mixed;
  blk_t mid;

  always_comb begin
    mixed = state_i ^ key_i;
    if (ctrl_i.dec) begin
      mid      = ctrl_i.perm ? transpose16(mixed) : mixed;
      result_o = ctrl_i.sub ? sub_nibbles(mid, 1'b1) : mid;
    end else begin
      mid      = ctrl_i.sub ? sub_nibbles(mixed, 1'b0) : mixed;
      result_o = ctrl_i.perm ? transpose16(mid) : mid;
    end
  end

endmodule

### sv/spn16_block_cipher.sv
// ----------------------------------------------------------------------------
// spn16_block_cipher
// Iterative 16-bit substitution-permutation block cipher with an on-chip
// key schedule.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  req_i     in   valid/ready    req_type (0 encrypt, 1 decrypt), block_in
//  rsp_o     out  valid/ready    block_out
//  cfg       in   cfg_we_i only  cfg_wdata_i (base key)
//
// Each request makes one pass of the shared round unit per round key, one
// round key per cycle, and a new request is taken only as the previous one
// retires. The next request is taken in the final round cycle.
// After reset, and after every base key write, the schedule is rebuilt in the
// same unit; req_i.ready stays low during that time.
// A held response stalls the final round until the output register frees.

`include "spn16_block_cipher_defines.svh"

module spn16_block_cipher import spn16_pkg::*; #(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  blk_t               cfg_wdata_i,
  spn16_req_if.sink          req_i,
  spn16_rsp_if.source        rsp_o
);

  localparam int unsigned NKEYS = ROUNDS + 1;
  localparam int unsigned KIW   = $clog2(NKEYS);
  localparam logic [KIW-1:0] LAST = KIW'(ROUNDS);

  // Sequencer state, step counter and the working block. During a key
  // build the working block register carries the running key.
  state_e         state_q, state_d;
  logic [KIW-1:0] cnt_q, cnt_d;
  blk_t           s_q, s_d;
  op_e            op_q, op_d;
  blk_t           out_q;
  logic           out_vld_q;

  // Round key store, written one entry per cycle by the schedule build.
  blk_t           key_mem [NKEYS];

  logic           last;
  logic           out_free;
  logic           finish;
  logic           accept;
  logic [KIW-1:0] kidx;
  blk_t           rk;
  rnd_ctrl_t      ctrl;
  blk_t           res;

  assign last     = (cnt_q == LAST);
  assign out_free = !out_vld_q || rsp_o.ready;
  // The final round of a request retires only when the output register
  // can take the result.
  assign finish   = (state_q == ST_RUN) && last && out_free;
  // A key write has priority; requests are never taken in the same cycle.
  assign req_i.ready = !cfg_we_i && ((state_q == ST_IDLE) || finish);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.block_out = out_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_KEYGEN: begin
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish && !accept) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = ST_KEYGEN;
    end
  end

  // Round unit control. In the cipher direction the last round skips the
  // transpose and the closing step is a bare key xor. The decipher
  // direction mirrors that: the first step skips the transpose, and round
  // keys are read from the top of the store downward.
  always_comb begin
    kidx = cnt_q;
    rk   = '0;
    ctrl = '{dec: 1'b0, perm: 1'b1, sub: 1'b1};
    case (state_q)
      ST_KEYGEN: begin
        // Key build: S-box then transpose applied to the running key.
        ctrl = '{dec: 1'b0, perm: 1'b1, sub: 1'b1};
      end
      ST_RUN: begin
        if (op_q == OP_DEC) begin
          kidx      = LAST - cnt_q;
          ctrl.dec  = 1'b1;
          ctrl.perm = (cnt_q != '0) && !last;
        end else begin
          kidx      = cnt_q;
          ctrl.dec  = 1'b0;
          ctrl.perm = !last && (cnt_q != LAST - KIW'(1));
        end
        ctrl.sub = !last;
        rk       = key_mem[kidx];
      end
      default: begin
        ctrl = '{dec: 1'b0, perm: 1'b0, sub: 1'b0};
      end
    endcase
  end

  spn16_round u_round (
    .state_i  (s_q),
    .key_i    (rk),
    .ctrl_i   (ctrl),
    .result_o (res)
  );

  // Datapath next values.
  always_comb begin
    cnt_d = cnt_q;
    s_d   = s_q;
    op_d  = op_q;
    case (state_q)
      ST_KEYGEN: begin
        s_d   = res;
        cnt_d = last ? '0 : cnt_q + KIW'(1);
      end
      ST_RUN: begin
        if (!last) begin
          s_d   = res;
          cnt_d = cnt_q + KIW'(1);
        end else if (finish) begin
          cnt_d = '0;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
    if (accept) begin
      s_d  = req_i.block_in;
      op_d = op_e'(req_i.req_type);
    end
    if (cfg_we_i) begin
      s_d   = cfg_wdata_i;
      cnt_d = '0;
    end
  end

  // Control registers. The working block resets to zero so that the
  // schedule built right after reset is the one for a zero base key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_KEYGEN;
      cnt_q     <= '0;
      s_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      s_q     <= s_d;
      if (finish) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    if (finish) begin
      out_q <= res;
    end
    if (state_q == ST_KEYGEN) begin
      key_mem[cnt_q] <= res;
    end
  end

  // The block never takes a request while the schedule is being rebuilt.
  `SPN16_ASSERT(a_no_req_in_keygen, clk_i, rst_ni, (state_q == ST_KEYGEN) |-> !req_i.ready, "request taken during key build")
  // The step counter never passes the last round key.
  `SPN16_ASSERT_ALWAYS(a_cnt_bound, clk_i, cnt_q <= LAST, "round counter out of range")
  // A taken request always starts from the first round.
  `SPN16_ASSERT(a_start_round, clk_i, rst_ni, (req_i.valid && req_i.ready) |=> (state_q == ST_RUN && cnt_q == '0), "request did not start at round zero")
  // A new response only appears after the final round of a request.
  `SPN16_ASSERT(a_rsp_from_run, clk_i, rst_ni, $rose(rsp_o.valid) |-> $past(state_q == ST_RUN && cnt_q == LAST), "response without a finished request")

endmodule

### verif/spn16_block_cipher_test.sv
// ----------------------------------------------------------------------------
// spn16_block_cipher_test
// Self-checking testbench of the 16-bit SPN block cipher. Encrypt and decrypt
// requests are driven under several base keys, each response is predicted
// from a local copy of the key schedule and compared in arrival order.
// ----------------------------------------------------------------------------
module spn16_block_cipher_test import spn16_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_ROUNDS = ROUNDS_DEF;
  localparam int unsigned NUM_KEYS   = NUM_ROUNDS + 1;
  // Longest stretch of cycles with no accepted request or response that a
  // correct run can show: key rebuilds, drains and long receiver stalls all
  // stay far below this.
  localparam int unsigned STALL_LIMIT = 4000;
  // Cycles to wait once nothing is outstanding.
  localparam int unsigned SETTLE_CYCLES = 2 * NUM_KEYS;

  // One request as the driver presents it.
  typedef struct packed {
    op_e  op;
    blk_t blk;
  } cipher_req_t;

  // Our own substitution tables, the forward box and its inverse.
  localparam logic [3:0] FWD_SBOX [16] = '{
    4'h6, 4'h4, 4'hC, 4'h5, 4'h0, 4'h7, 4'h2, 4'hE,
    4'h1, 4'hF, 4'h3, 4'hD, 4'h8, 4'hA, 4'h9, 4'hB
  };
  localparam logic [3:0] INV_SBOX [16] = '{
    4'h4, 4'h8, 4'h6, 4'hA, 4'h1, 4'h3, 4'h0, 4'h5,
    4'hC, 4'hE, 4'hD, 4'hF, 4'h2, 4'hB, 4'h7, 4'h9
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  blk_t cfg_wdata_i;

  spn16_req_if req_if ();
  spn16_rsp_if rsp_if ();

  spn16_block_cipher #(
    .ROUNDS(NUM_ROUNDS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Requests waiting to be driven, and the blocks the cipher owes us.
  cipher_req_t pending_reqs[$];
  blk_t        expected_blocks[$];

  // Local copy of the round keys, rebuilt whenever we write the base key.
  blk_t round_keys [NUM_KEYS];

  // Idle rates in percent for the sending and receiving sides.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  int unsigned error_count;
  int unsigned quiet_cycles;
  // Set by the monitor when the presented request was taken at the last
  // rising edge, cleared by the driver once it has moved on.
  bit          req_taken;
  cipher_req_t next_req;

  // --------------------------------------------------------------------------
  // Clock: 12 ns period.
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Cipher predictor.
  // --------------------------------------------------------------------------

  // Substitute all four nibbles through the forward or the inverse box.
  function automatic blk_t sbox_layer(input blk_t x, input bit inv);
    blk_t r;
    r = '0;
    for (int n = 0; n < 4; n++) begin
      r[4*n +: 4] = inv ? INV_SBOX[x[4*n +: 4]] : FWD_SBOX[x[4*n +: 4]];
    end
    return r;
  endfunction

  // A 4x4 bit transpose: bit i comes from bit 4*(i mod 4) + i/4. Applying it
  // twice gives the original block back, so decrypt reuses it unchanged.
  function automatic blk_t bit_transpose(input blk_t x);
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      r[i] = x[4 * (i % 4) + i / 4];
    end
    return r;
  endfunction

  // Key k is the base key after k+1 passes of substitute-then-transpose.
  function automatic void load_round_keys(input blk_t base);
    blk_t k;
    k = base;
    for (int i = 0; i < NUM_KEYS; i++) begin
      k = bit_transpose(sbox_layer(k, 1'b0));
      round_keys[i] = k;
    end
  endfunction

  // Expected output block for one request under the current round keys.
  // Encrypt runs NUM_ROUNDS-1 full rounds and a last round without the
  // transpose, closed by the final key. Decrypt walks the same steps back.
  function automatic blk_t cipher_block(input op_e op, input blk_t blk);
    blk_t s;
    s = blk;
    if (op == OP_ENC) begin
      for (int r = 0; r < NUM_ROUNDS - 1; r++) begin
        s = bit_transpose(sbox_layer(s ^ round_keys[r], 1'b0));
      end
      s = sbox_layer(s ^ round_keys[NUM_ROUNDS-1], 1'b0) ^ round_keys[NUM_ROUNDS];
    end else begin
      s = sbox_layer(s ^ round_keys[NUM_ROUNDS], 1'b1) ^ round_keys[NUM_ROUNDS-1];
      for (int k = NUM_ROUNDS - 1; k > 0; k--) begin
        s = sbox_layer(bit_transpose(s), 1'b1) ^ round_keys[k-1];
      end
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver. Inputs move only at the falling edge. A request stays on the bus
  // until the monitor has seen it taken; then the next one follows right
  // away unless the sender decides to idle this cycle.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_reqs.pop_front();
          req_if.valid    <= 1'b1;
          req_if.req_type <= next_req.op;
          req_if.block_in <= next_req.blk;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      req_taken = 1'b0;
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and scoreboard, sampled at the rising edge. Every accepted
  // request pushes its predicted block; every accepted response is compared
  // with the oldest one. The watchdog ends the run if the handshakes stop.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        expected_blocks.push_back(cipher_block(op_e'(req_if.req_type), req_if.block_in));
        req_taken = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("response %h with no request outstanding",
                                    rsp_if.block_out));
        end else if (rsp_if.block_out !== expected_blocks[0]) begin
          report_mismatch($sformatf("block_out %h, expected %h",
                                    rsp_if.block_out, expected_blocks[0]));
          void'(expected_blocks.pop_front());
        end else begin
          void'(expected_blocks.pop_front());
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("[%0t] ERROR: no handshake for %0d cycles", $realtime, quiet_cycles);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Blocks lean on the corners now and then: all zeros, all ones, a single
  // set bit and a single clear bit; otherwise uniform.
  function automatic blk_t pick_block();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return blk_t'(1) << $urandom_range(15);
      3: return ~(blk_t'(1) << $urandom_range(15));
      default: return blk_t'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic void queue_req(input op_e op, input blk_t blk);
    cipher_req_t r;
    r.op  = op;
    r.blk = blk;
    pending_reqs.push_back(r);
  endfunction

  // Random requests. Some come as round-trip pairs: a block is encrypted
  // and its ciphertext is sent back to be decrypted, or the other way round.
  function automatic void queue_random(input int unsigned count);
    blk_t b;
    op_e  op;
    int unsigned n;
    n = 0;
    while (n < count) begin
      b  = pick_block();
      op = op_e'($urandom_range(1));
      queue_req(op, b);
      n++;
      if (n < count && $urandom_range(4) == 0) begin
        queue_req(op == OP_ENC ? OP_DEC : OP_ENC, cipher_block(op, b));
        n++;
      end
    end
  endfunction

  // Wait at falling edges until the driver has nothing left and every
  // predicted response has come back.
  task automatic drain();
    while (pending_reqs.size() != 0 || req_if.valid || expected_blocks.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Base key write while the cipher is idle. The block rebuilds its schedule
  // afterwards and holds off requests by itself, so no extra wait is needed.
  task automatic write_base_key(input blk_t key);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= key;
    load_round_keys(key);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = OP_ENC;
    req_if.block_in = '0;
    rsp_if.ready    = 1'b0;
    send_idle_pct   = 29;
    recv_idle_pct   = 58;
    error_count     = 0;
    quiet_cycles    = 0;
    req_taken       = 1'b0;
    // After reset the cipher holds the schedule of a zero base key.
    load_round_keys('0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under the reset key: corner blocks in both
    // directions, alternating patterns, single bits and two round trips.
    queue_req(OP_ENC, 16'h0000);
    queue_req(OP_ENC, 16'hFFFF);
    queue_req(OP_DEC, 16'h0000);
    queue_req(OP_DEC, 16'hFFFF);
    queue_req(OP_ENC, 16'h5555);
    queue_req(OP_DEC, 16'hAAAA);
    queue_req(OP_ENC, 16'h0001);
    queue_req(OP_DEC, 16'h8000);
    queue_req(OP_ENC, 16'h00FF);
    queue_req(OP_DEC, 16'hFF00);
    queue_req(OP_ENC, 16'h0F0F);
    queue_req(OP_DEC, 16'hF0F0);
    queue_req(OP_ENC, 16'h1234);
    queue_req(OP_DEC, cipher_block(OP_ENC, 16'h1234));
    queue_req(OP_DEC, 16'hBEEF);
    queue_req(OP_ENC, cipher_block(OP_DEC, 16'hBEEF));
    queue_req(OP_ENC, 16'h8001);
    queue_req(OP_DEC, 16'h7FFE);
    drain();

    // Sender idles 29%, receiver 58%. Halfway through, the sender pauses
    // until every outstanding response has come back.
    write_base_key(16'hFFFF);
    queue_random(290);
    drain();
    queue_random(290);

    // Roles swapped: sender idles 58%, receiver 29%.
    write_base_key(blk_t'($urandom_range(16'hFFFF)));
    send_idle_pct = 58;
    recv_idle_pct = 29;
    queue_random(580);

    // No idling on either side: back-to-back requests and a receiver that
    // never stalls, under the zero key written explicitly and then another
    // random one.
    write_base_key(16'h0000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(290);
    write_base_key(blk_t'($urandom_range(16'hFFFF)));
    queue_random(290);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_blocks.size() != 0) begin
      report_mismatch($sformatf("%0d responses never arrived", expected_blocks.size()));
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/spn16_pkg.sv
sv/spn16_req_if.sv
sv/spn16_rsp_if.sv
sv/spn16_round.sv
sv/spn16_block_cipher.sv
verif/spn16_block_cipher_test.sv
